/* rtl/core/bds_pkg.sv */
// ----------------------------------------------------------------------------
// bds_pkg
// shared types and constants of the 2x2 box downsampler
// ----------------------------------------------------------------------------
`default_nettype none

package bds_pkg;

   // pixel packing
   localparam int CH_N   = 3;
   localparam int CH_W   = 8;
   localparam int PIX_W  = CH_N * CH_W;
   // sum of two channel values
   localparam int PAIR_W = CH_W + 1;
   // sum of four channel values
   localparam int QUAD_W = CH_W + 2;

   // configuration port
   localparam int REG_W = 12;
   localparam int IDX_W = 4;
   localparam logic [IDX_W-1:0] CSR_WIDTH_IDX  = 4'd0;
   localparam logic [IDX_W-1:0] CSR_HEIGHT_IDX = 4'd1;

   // rows
   localparam int ROW_W      = 11;
   localparam int HEIGHT_MAX = 2048;
   localparam int DIM_MIN    = 2;
   localparam int DIM_RESET  = 256;

   // one horizontal pixel pair handed from front to back
   typedef struct packed {
      logic                             rd;    // odd row: add to stored row sum
      logic                             last;  // final output of the frame
      logic [CH_N-1:0][PAIR_W-1:0]      sum;   // per channel pair sum
   } pair_op_type;

endpackage

`default_nettype wire

/* rtl/core/bds_front.sv */
// ----------------------------------------------------------------------------
// bds_front
// accepts pixels, tracks column and row, folds horizontal pairs into ops
// ----------------------------------------------------------------------------
`default_nettype none

module bds_front
   import bds_pkg::*;
#(
   parameter int MAX_WIDTH = 2048,
   parameter int SLOT_W    = 10
) (
   input  wire                    clock,
   input  wire                    reset,
   // pixel input
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire  [PIX_W-1:0]       req_pixel,
   // configuration writes
   input  wire                    csr_we,
   input  wire  [IDX_W-1:0]       csr_index,
   input  wire  [REG_W-1:0]       csr_wdata,
   // op queue
   input  wire                    q_full,
   output logic                   q_push,
   output pair_op_type            q_op,
   output logic [SLOT_W-1:0]      q_slot
);

   localparam int COL_W   = SLOT_W + 1;
   localparam int CW      = (COL_W + 1 > REG_W) ? COL_W + 1 : REG_W;
   // power-on width, held within the widest supported row
   localparam int W_RESET = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] w_last_ff, w_last_in;
   logic [COL_W-1:0] w_pair_last_ff, w_pair_last_in;
   logic [ROW_W-1:0] h_last_ff, h_last_in;
   logic [ROW_W-1:0] h_pair_last_ff, h_pair_last_in;
   logic [PIX_W-1:0] even_px_ff;

   logic             accept;
   logic [CW-1:0]    w_raw;
   logic [CW-1:0]    w_clamp;
   logic [REG_W-1:0] h_clamp;

   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;

   // clamp incoming dimensions
   always_comb begin
      w_raw = CW'(csr_wdata);
      if (w_raw < CW'(DIM_MIN)) begin
         w_clamp = CW'(DIM_MIN);
      end else if (w_raw > CW'(MAX_WIDTH)) begin
         w_clamp = CW'(MAX_WIDTH);
      end else begin
         w_clamp = w_raw;
      end
      if (csr_wdata < REG_W'(DIM_MIN)) begin
         h_clamp = REG_W'(DIM_MIN);
      end else if (csr_wdata > REG_W'(HEIGHT_MAX)) begin
         h_clamp = REG_W'(HEIGHT_MAX);
      end else begin
         h_clamp = csr_wdata;
      end
   end

   // limit registers
   always_comb begin
      w_last_in      = w_last_ff;
      w_pair_last_in = w_pair_last_ff;
      h_last_in      = h_last_ff;
      h_pair_last_in = h_pair_last_ff;
      if (csr_we && csr_index == CSR_WIDTH_IDX) begin
         w_last_in      = COL_W'(w_clamp - CW'(1));
         w_pair_last_in = COL_W'((w_clamp & ~CW'(1)) - CW'(1));
      end
      if (csr_we && csr_index == CSR_HEIGHT_IDX) begin
         h_last_in      = ROW_W'(h_clamp - REG_W'(1));
         h_pair_last_in = ROW_W'((h_clamp & ~REG_W'(1)) - REG_W'(1));
      end
   end

   // raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_we && (csr_index == CSR_WIDTH_IDX || csr_index == CSR_HEIGHT_IDX)) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == w_last_ff) begin
            col_in = '0;
            row_in = (row_ff == h_last_ff) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         w_last_ff      <= COL_W'(W_RESET - 1);
         w_pair_last_ff <= COL_W'((W_RESET & ~1) - 1);
         h_last_ff      <= ROW_W'(DIM_RESET - 1);
         h_pair_last_ff <= ROW_W'(DIM_RESET - 1);
      end else begin
         col_ff         <= col_in;
         row_ff         <= row_in;
         w_last_ff      <= w_last_in;
         w_pair_last_ff <= w_pair_last_in;
         h_last_ff      <= h_last_in;
         h_pair_last_ff <= h_pair_last_in;
      end
   end

   // hold the even column pixel until its partner arrives
   always_ff @(posedge clock) begin
      if (accept && !col_ff[0]) begin
         even_px_ff <= req_pixel;
      end
   end

   // odd column completes a pair
   always_comb begin
      q_push  = accept && col_ff[0];
      q_slot  = col_ff[COL_W-1:1];
      q_op.rd = row_ff[0];
      q_op.last = (col_ff == w_pair_last_ff) && (row_ff == h_pair_last_ff);
      for (int c = 0; c < CH_N; c++) begin
         q_op.sum[c] = {1'b0, even_px_ff[c*CH_W +: CH_W]} + {1'b0, req_pixel[c*CH_W +: CH_W]};
      end
   end

endmodule

`default_nettype wire

/* rtl/core/bds_queue.sv */
// ----------------------------------------------------------------------------
// bds_queue
// small fifo between pair front and accumulate back
// ----------------------------------------------------------------------------
`default_nettype none

module bds_queue #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 4
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  wire  [DATA_W-1:0] push_data,
   output logic              full,
   input  wire               pop,
   output logic              not_empty,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = store_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/bds_back.sv */
// ----------------------------------------------------------------------------
// bds_back
// line store of row pair sums, vertical accumulate, rounding and output
// ----------------------------------------------------------------------------
`default_nettype none

module bds_back
   import bds_pkg::*;
#(
   parameter int DEPTH  = 1024,
   parameter int SLOT_W = 10
) (
   input  wire                 clock,
   input  wire                 reset,
   // op queue
   input  wire                 q_not_empty,
   input  pair_op_type         q_op,
   input  wire  [SLOT_W-1:0]   q_slot,
   output logic                q_pop,
   // results
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [PIX_W-1:0]    rsp_out_pixel,
   output logic                rsp_frame_last
);

   localparam int ROWSUM_W = CH_N * PAIR_W;

   logic [ROWSUM_W-1:0]          line_mem [DEPTH];
   logic [ROWSUM_W-1:0]          rd_data_ff;
   logic                         s1_valid_ff;
   logic [CH_N-1:0][PAIR_W-1:0]  s1_sum_ff;
   logic                         s1_last_ff;
   logic                         rsp_valid_ff;
   logic [PIX_W-1:0]             rsp_pixel_ff, rsp_pixel_in;
   logic                         rsp_last_ff;
   logic                         out_free, s1_ready;
   logic [QUAD_W-1:0]            quad;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_ready = !s1_valid_ff || out_free;
   assign q_pop    = q_not_empty && s1_ready;

   // line store: even rows write pair sums, odd rows read them back
   always_ff @(posedge clock) begin
      if (q_pop) begin
         if (q_op.rd) begin
            rd_data_ff <= line_mem[q_slot];
         end else begin
            line_mem[q_slot] <= q_op.sum;
         end
      end
   end

   // read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= q_pop && q_op.rd;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_sum_ff  <= q_op.sum;
         s1_last_ff <= q_op.last;
      end
   end

   // four pixel sum with rounding
   always_comb begin
      rsp_pixel_in = '0;
      quad         = '0;
      for (int c = 0; c < CH_N; c++) begin
         quad = QUAD_W'(rd_data_ff[c*PAIR_W +: PAIR_W]) + QUAD_W'(s1_sum_ff[c])
              + QUAD_W'(2);
         rsp_pixel_in[c*CH_W +: CH_W] = quad[QUAD_W-1:2];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_pixel  = rsp_pixel_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

`default_nettype wire

/* rtl/core/box_downsample_2x2_rgb_core.sv */
// The output for a 2x2 block passes the op queue, read stage and output register.
// Throughput: one pixel per cycle; the back end pops one pixel pair per cycle; both can stall.
// The line store gets one access per pixel pair, so its single port is never the limit.
// Reset clears counters, queue and output valid; width and height return to 256.
// Line store contents are not cleared: each entry is written on an even row before use.
// ----------------------------------------------------------------------------
// box_downsample_2x2_rgb_core
// 2x2 box filter downsampler for packed rgb pixels in raster order
// ----------------------------------------------------------------------------
`default_nettype none

module box_downsample_2x2_rgb_core
   import bds_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  wire               clock,
   input  wire               reset,
   // pixel input
   input  wire               req_valid,
   output logic              req_stall,
   input  wire  [PIX_W-1:0]  req_pixel,
   // results
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic [PIX_W-1:0]  rsp_out_pixel,
   output logic              rsp_frame_last,
   // configuration writes
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire  [IDX_W-1:0]  csr_index,
   input  wire  [REG_W-1:0]  csr_wdata
);

   localparam int DEPTH   = (MAX_WIDTH + 1) / 2;
   localparam int SLOT_W  = $clog2(DEPTH);
   localparam int OP_W    = $bits(pair_op_type);
   localparam int QDATA_W = OP_W + SLOT_W;
   localparam int Q_DEPTH = 4;

   pair_op_type         f_op, b_op;
   logic [SLOT_W-1:0]   f_slot, b_slot;
   logic                q_push, q_full, q_pop, q_not_empty;
   logic [QDATA_W-1:0]  q_rd_data;

   // configuration is always taken
   assign csr_ready = 1'b1;

   // pixel front end
   bds_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .SLOT_W    (SLOT_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_pixel (req_pixel),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_op      (f_op),
      .q_slot    (f_slot)
   );

   // pair op queue
   bds_queue #(
      .DATA_W (QDATA_W),
      .DEPTH  (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_op, f_slot}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_rd_data)
   );

   assign b_op   = pair_op_type'(q_rd_data[QDATA_W-1:SLOT_W]);
   assign b_slot = q_rd_data[SLOT_W-1:0];

   // accumulate back end
   bds_back #(
      .DEPTH  (DEPTH),
      .SLOT_W (SLOT_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_op           (b_op),
      .q_slot         (b_slot),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_pixel  (rsp_out_pixel),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

`default_nettype wire

/* tb/box_downsample_2x2_rgb_core_tb.sv */
// ----------------------------------------------------------------------------
// box_downsample_2x2_rgb_core_tb
// Self-checking bench for the 2x2 box downsampler. Pixel frames of many sizes
// are streamed in raster order with random gaps and output back-pressure. A
// scoreboard keeps its own line store and counters. It predicts each averaged
// pixel and its end-of-frame flag, and it compares them with what comes out.
// ----------------------------------------------------------------------------

module box_downsample_2x2_rgb_core_tb
   import bds_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W          = 2048;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_ITEMS   = 480;

   // one expected output pixel
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } avg_px_type;

   // line store and counter mirror, plus the queue of expected averages
   class box_avg_scoreboard;
      logic [3*QUAD_W-1:0] col_sums [MAX_W/2];
      int                  col_idx;
      int                  row_idx;
      int                  width_reg;
      int                  height_reg;
      int                  errors;
      avg_px_type          want_q [$];

      function new();
         col_idx    = 0;
         row_idx    = 0;
         width_reg  = DIM_RESET;
         height_reg = DIM_RESET;
         errors     = 0;
         foreach (col_sums[k]) col_sums[k] = '0;
      endfunction

      function int clamp_dim(int v, int hi);
         if (v < DIM_MIN) return DIM_MIN;
         if (v > hi) return hi;
         return v;
      endfunction

      function int frame_pixels();
         return clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, HEIGHT_MAX);
      endfunction

      function int pending();
         return want_q.size();
      endfunction

      // a write to either dimension restarts the frame, store keeps its data
      function void write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
         case (idx)
            CSR_WIDTH_IDX: width_reg = int'(data);
            CSR_HEIGHT_IDX: height_reg = int'(data);
            default: return;
         endcase
         col_idx = 0;
         row_idx = 0;
      endfunction

      // accumulate one source pixel, queue an average on odd column of odd row
      function void add_pixel(logic [PIX_W-1:0] px);
         int                  w;
         int                  h;
         int                  slot;
         logic                fresh;
         logic [3*QUAD_W-1:0] entry;
         logic [QUAD_W-1:0]   s;
         avg_px_type          res;
         w     = clamp_dim(width_reg, MAX_W);
         h     = clamp_dim(height_reg, HEIGHT_MAX);
         slot  = col_idx >> 1;
         fresh = (col_idx % 2 == 0) && (row_idx % 2 == 0);
         entry = col_sums[slot];
         for (int c = 0; c < CH_N; c++) begin
            s = fresh ? '0 : entry[QUAD_W*c +: QUAD_W];
            s = s + QUAD_W'(px[CH_W*c +: CH_W]);
            entry[QUAD_W*c +: QUAD_W] = s;
         end
         col_sums[slot] = entry;
         if ((col_idx % 2 == 1) && (row_idx % 2 == 1)) begin
            for (int c = 0; c < CH_N; c++)
               res.pixel[CH_W*c +: CH_W] = CH_W'((int'(entry[QUAD_W*c +: QUAD_W]) + 2) >> 2);
            res.last = (col_idx == (w & ~1) - 1) && (row_idx == (h & ~1) - 1);
            want_q.push_back(res);
         end
         if (col_idx + 1 >= w) begin
            col_idx = 0;
            row_idx = (row_idx + 1 >= h) ? 0 : row_idx + 1;
         end else begin
            col_idx = col_idx + 1;
         end
      endfunction

      // compare one output pixel against the oldest expectation
      function void check_output(logic [PIX_W-1:0] px, logic last);
         avg_px_type want;
         if (want_q.size() == 0) begin
            $error("unexpected output: out_pixel %h frame_last %b", px, last);
            errors++;
            return;
         end
         want = want_q.pop_front();
         if (px !== want.pixel) begin
            $error("out_pixel mismatch: expected %h, got %h", want.pixel, px);
            errors++;
         end
         if (last !== want.last) begin
            $error("frame_last mismatch: expected %b, got %b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic [PIX_W-1:0]   req_pixel      = '0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic [PIX_W-1:0]   rsp_out_pixel;
   logic               rsp_frame_last;
   logic               csr_valid      = 1'b0;
   logic               csr_ready;
   logic [IDX_W-1:0]   csr_index      = '0;
   logic [REG_W-1:0]   csr_wdata      = '0;

   box_avg_scoreboard  sb;
   bit                 steady         = 1'b0;
   int                 outputs_seen   = 0;
   int                 idle_cycles    = 0;

   box_downsample_2x2_rgb_core #(
      .MAX_WIDTH(MAX_W)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_pixel (rsp_out_pixel),
      .rsp_frame_last(rsp_frame_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // monitor: note accepted items, check results, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            sb.add_pixel(req_pixel);
         if (rsp_valid && !rsp_stall) begin
            sb.check_output(rsp_out_pixel, rsp_frame_last);
            outputs_seen++;
         end
         if ((csr_valid && csr_ready) || (req_valid && !req_stall) ||
             (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL box_downsample_2x2_rgb_core");
            $finish;
         end
      end
   end

   // receiver: random stalls, one long hold-off early in the run
   initial begin
      int  hold_left;
      bit  held;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!held && outputs_seen >= 20) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 37);
         end
      end
   end

   // drive one pixel, with random gaps ahead of it
   task automatic send_pixel(input logic [PIX_W-1:0] px);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid and let the block drain before touching registers
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(15))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom());
      endcase
   endfunction

   task automatic send_random(input int n);
      for (int k = 0; k < n; k++) send_pixel(random_pixel());
   endtask

   // stimulus
   initial begin
      int                n;
      int                wv;
      int                hv;
      int                sel;
      int                fp;
      int                rand_items;
      logic [PIX_W-1:0]  dir_px [8];
      sb = new();
      dir_px = '{24'hffffff, 24'hffffff, 24'h000000, 24'h000001,
                 24'hffffff, 24'hffffff, 24'h000101, 24'h010000};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // power-on dimensions, two full rows; the long hold-off falls here
      send_random(2 * DIM_RESET);

      // full-scale and rounding sums on a 4x2 frame
      wait_idle();
      write_reg(CSR_WIDTH_IDX, 12'd4);
      write_reg(CSR_HEIGHT_IDX, 12'd2);
      foreach (dir_px[k]) send_pixel(dir_px[k]);

      // odd last column and row dropped, stray index write leaves the frame alone
      wait_idle();
      write_reg(CSR_WIDTH_IDX, 12'd5);
      write_reg(CSR_HEIGHT_IDX, 12'd3);
      send_random(7);
      wait_idle();
      write_reg(IDX_W'((1 << IDX_W) - 1), '1);
      send_random(8);

      // dimensions below the minimum clamp up
      wait_idle();
      write_reg(CSR_WIDTH_IDX, 12'd0);
      write_reg(CSR_HEIGHT_IDX, 12'd1);
      send_random(4);

      // widest row, clamped from the register's top value, only its first pixels
      wait_idle();
      write_reg(CSR_WIDTH_IDX, '1);
      write_reg(CSR_HEIGHT_IDX, 12'd2);
      send_random(64);

      // one whole frame with no gaps on either side
      wait_idle();
      write_reg(CSR_WIDTH_IDX, 12'd16);
      write_reg(CSR_HEIGHT_IDX, 12'd16);
      steady = 1'b1;
      send_random(256);
      steady = 1'b0;

      // tallest frame, only its first rows
      wait_idle();
      write_reg(CSR_WIDTH_IDX, 12'd1);
      write_reg(CSR_HEIGHT_IDX, '1);
      send_random(48);
      wait_idle();
      write_reg(CSR_HEIGHT_IDX, 12'(HEIGHT_MAX));
      send_random(20);

      // random small frames, sometimes cut short by a reconfiguration
      rand_items = 0;
      while (rand_items < RANDOM_ITEMS) begin
         wait_idle();
         sel = $urandom_range(9);
         wv  = (sel < 7) ? $urandom_range(2, 12) :
               (sel < 8) ? $urandom_range(0, 1) : $urandom_range(13, 64);
         sel = $urandom_range(9);
         hv  = (sel < 7) ? $urandom_range(2, 10) :
               (sel < 8) ? $urandom_range(0, 1) : $urandom_range(11, 16);
         sel = $urandom_range(7);
         if (sel == 0) begin
            write_reg(CSR_WIDTH_IDX, REG_W'(wv));
         end else if (sel == 1) begin
            write_reg(CSR_HEIGHT_IDX, REG_W'(hv));
         end else if (sel < 5) begin
            write_reg(CSR_WIDTH_IDX, REG_W'(wv));
            write_reg(CSR_HEIGHT_IDX, REG_W'(hv));
         end else begin
            write_reg(CSR_HEIGHT_IDX, REG_W'(hv));
            write_reg(CSR_WIDTH_IDX, REG_W'(wv));
         end
         if ($urandom_range(3) == 0)
            write_reg(IDX_W'($urandom_range(int'(CSR_HEIGHT_IDX) + 1, (1 << IDX_W) - 1)),
                      REG_W'($urandom()));
         fp = sb.frame_pixels();
         n  = fp * $urandom_range(1, 3);
         if ($urandom_range(3) == 0)
            n = n + $urandom_range(fp - 1);
         // keep the total item count near its budget
         if (n > RANDOM_ITEMS - rand_items)
            n = RANDOM_ITEMS - rand_items;
         send_random(n);
         rand_items += n;
      end

      // drain and report
      wait_idle();
      if (sb.errors == 0)
         $display("PASS box_downsample_2x2_rgb_core");
      else
         $display("FAIL box_downsample_2x2_rgb_core");
      $finish;
   end

endmodule

/* files.f */
rtl/core/bds_pkg.sv
rtl/core/bds_front.sv
rtl/core/bds_queue.sv
rtl/core/bds_back.sv
rtl/core/box_downsample_2x2_rgb_core.sv
tb/box_downsample_2x2_rgb_core_tb.sv
